// ----- hdl/sfr_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the sync frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 4096;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam int LEN_W = 16;

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_HEAD  = 3'd2,
    PH_BODY  = 3'd3,
    PH_CRC   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    HDR_LEN_LO = 2'd0,
    HDR_LEN_HI = 2'd1,
    HDR_SEQ    = 2'd2,
    HDR_CMD    = 2'd3
  } hdr_t;

  typedef enum logic {
    KIND_BODY = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // CRC-16/CCITT, MSB first, one byte per call.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sync_frame_receiver_crc16_top.sv -----
// Sync frame receiver: hunts A5 5A, parses header and body, checks CRC-16.
// The result of an accepted item is registered into the output register in the next cycle.
// Throughput: one item per cycle; a held result stalls input only while out_ready is low.
// Reset (rst, synchronous) returns to hunting the first sync byte, CRC at FFFF.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sync_frame_receiver_crc16_top #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       body_byte,
  output logic [11:0]      body_index,
  output logic [7:0]       frame_seq,
  output logic [7:0]       frame_cmd,
  output logic [12:0]      frame_length,
  output logic             crc_ok
);
  import sfr_pkg::*;

  localparam logic [LEN_W:0] MAX_LEN = (LEN_W+1)'(MAX_PAYLOAD);

  phase_t             phase, phase_next;
  hdr_t               header_count, header_count_next;
  logic [7:0]         length_low, length_low_next;
  logic [LEN_W-1:0]   body_length, body_length_next;
  logic [7:0]         seq_byte, seq_byte_next;
  logic [7:0]         cmd_byte, cmd_byte_next;
  logic [LEN_W-1:0]   body_count, body_count_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [7:0]         crc_high, crc_high_next;
  logic               crc_count, crc_count_next;

  logic               res_valid;
  kind_t              res_kind;
  logic [7:0]         res_byte;
  logic [11:0]        res_index;
  logic               res_ok;
  logic               accept;
  logic [LEN_W:0]     count_inc;
  logic [LEN_W-1:0]   len_full;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign count_inc = {1'b0, body_count} + 1'b1;
  assign len_full  = {rx_byte, length_low};

  // next state
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    length_low_next   = length_low;
    body_length_next  = body_length;
    seq_byte_next     = seq_byte;
    cmd_byte_next     = cmd_byte;
    body_count_next   = body_count;
    running_crc_next  = running_crc;
    crc_high_next     = crc_high;
    crc_count_next    = crc_count;
    if (func) begin
      phase_next = PH_HUNT0;
    end else begin
      unique case (phase)
        PH_HUNT1: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_next        = PH_HEAD;
            header_count_next = HDR_LEN_LO;
            running_crc_next  = CRC_INIT;
          end else if (rx_byte != SYNC_FIRST) begin
            phase_next = PH_HUNT0;
          end
        end
        PH_HEAD: begin
          unique case (header_count)
            HDR_LEN_LO: begin
              length_low_next   = rx_byte;
              header_count_next = HDR_LEN_HI;
            end
            HDR_LEN_HI: begin
              body_length_next  = len_full;
              header_count_next = HDR_SEQ;
            end
            HDR_SEQ: begin
              seq_byte_next     = rx_byte;
              running_crc_next  = crc_feed(running_crc, rx_byte);
              header_count_next = HDR_CMD;
            end
            default: begin
              cmd_byte_next     = rx_byte;
              running_crc_next  = crc_feed(running_crc, rx_byte);
              header_count_next = HDR_LEN_LO;
              body_count_next   = '0;
              crc_count_next    = 1'b0;
              if ({1'b0, body_length} > MAX_LEN) begin
                phase_next = PH_HUNT0;
              end else if (body_length != '0) begin
                phase_next = PH_BODY;
              end else begin
                phase_next = PH_CRC;
              end
            end
          endcase
        end
        PH_BODY: begin
          running_crc_next = crc_feed(running_crc, rx_byte);
          body_count_next  = count_inc[LEN_W-1:0];
          if (count_inc >= {1'b0, body_length}) begin
            phase_next     = PH_CRC;
            crc_count_next = 1'b0;
          end
        end
        PH_CRC: begin
          if (!crc_count) begin
            crc_high_next  = rx_byte;
            crc_count_next = 1'b1;
          end else begin
            crc_count_next = 1'b0;
            phase_next     = PH_HUNT0;
          end
        end
        default: begin
          phase_next = (rx_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  // result for the current item
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_BODY;
    res_byte  = '0;
    res_index = '0;
    res_ok    = 1'b0;
    if (!func) begin
      if (phase == PH_BODY) begin
        res_valid = 1'b1;
        res_byte  = rx_byte;
        res_index = body_count[11:0];
      end else if (phase == PH_CRC && crc_count) begin
        res_valid = 1'b1;
        res_kind  = KIND_END;
        res_ok    = ({crc_high, rx_byte} == running_crc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT0;
      header_count <= HDR_LEN_LO;
      length_low   <= '0;
      body_length  <= '0;
      seq_byte     <= '0;
      cmd_byte     <= '0;
      body_count   <= '0;
      running_crc  <= CRC_INIT;
      crc_high     <= '0;
      crc_count    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        length_low   <= length_low_next;
        body_length  <= body_length_next;
        seq_byte     <= seq_byte_next;
        cmd_byte     <= cmd_byte_next;
        body_count   <= body_count_next;
        running_crc  <= running_crc_next;
        crc_high     <= crc_high_next;
        crc_count    <= crc_count_next;
        out_valid    <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind         <= res_kind;
      body_byte    <= res_byte;
      body_index   <= res_index;
      frame_seq    <= seq_byte;
      frame_cmd    <= cmd_byte;
      frame_length <= body_length[12:0];
      crc_ok       <= res_ok;
    end
  end

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func) |=> !out_valid)
    else $error("idle item produced a result");

  a_body_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_count < body_length))
    else $error("body count reached length inside body");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> (body_byte == 8'h00 && body_index == 12'h000))
    else $error("frame end carries body data");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kind) |-> !crc_ok)
    else $error("crc_ok set on body item");

endmodule
`default_nettype wire
